@@ rtl/plt_pkg.sv @@
// ---------------------------------------------------------------------------
// plt_pkg
// Shared types and constants of the positional list table: sizes, command
// codes, sequencer states and the control bundle broadcast to the cells.
// ---------------------------------------------------------------------------
`default_nettype none

package plt_pkg;

  // Storage geometry.
  localparam int CAPACITY = 64;
  localparam int ENTRY_W  = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Port field widths.
  localparam int CMD_W   = 3;
  localparam int POS_W   = 7;
  localparam int ELEM_W  = 32;
  localparam int RDV_W   = 32;
  localparam int FND_W   = 7;
  localparam int LEN_W   = 7;
  localparam int IN_DW   = 40;
  localparam int OUT_DW  = 48;

  // Command codes carried on the input side-band.
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_GET    = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_LOCATE = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic               shift_up;
    logic               shift_down;
    logic [IDX_W-1:0]   slot;
    logic [ENTRY_W-1:0] elem;
    logic [CNT_W-1:0]   count;
  } plt_ctl_t;

endpackage

`default_nettype wire

@@ rtl/positional_list_table_core.sv @@
// ---------------------------------------------------------------------------
// positional_list_table_core
// Bounded ordered list of word entries with one-based positions.
//
// Input items carry a command on in_tuser (insert, get, delete, locate,
// clear) with a position and an element on in_tdata. Every item gives one
// result item on the out_ channel: status on out_tuser, and the value read
// or removed, the located position and the new list length on out_tdata.
// The entries live in a chain of cells; an insert or delete moves every
// entry above the slot by one place all together, and all cells compare
// against the element at once for a locate.
// Each item is captured in the idle state; in the execute state the chain
// updates and the result register loads, and no new item is taken until
// the item leaves execute. The result shows in the cycle after execute.
// If the receiver stalls, the result holds in the output register; the next
// item is still accepted and waits in execute until that register drains.
// Reset empties the list; entries stay unknown until an insert writes them,
// and no command can read an entry that was never written.
// ---------------------------------------------------------------------------
`default_nettype none

module positional_list_table_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [plt_pkg::IN_DW-1:0]   in_tdata,   // position[6:0], element[38:7]
  input  wire logic [plt_pkg::CMD_W-1:0]   in_tuser,   // cmd[2:0]
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [plt_pkg::OUT_DW-1:0]  out_tdata,  // read_value[31:0],
                                                       // found_position[38:32],
                                                       // list_length[45:39]
  output logic                             out_tuser   // status[0]
);

  plt_pkg::state_t             state_r, state_nxt;
  logic [plt_pkg::CMD_W-1:0]   cmd_r;
  logic [plt_pkg::POS_W-1:0]   pos_r;
  logic [plt_pkg::ENTRY_W-1:0] elem_r;
  logic [plt_pkg::CNT_W-1:0]   count_r, count_nxt;

  logic                        out_valid_r;
  logic                        status_r;
  logic [plt_pkg::RDV_W-1:0]   rdv_r;
  logic [plt_pkg::FND_W-1:0]   fnd_r;
  logic [plt_pkg::LEN_W-1:0]   len_r;

  logic                        in_acc;
  logic                        out_free;
  logic                        do_exec;
  logic                        ins_ok;
  logic                        rd_ok;
  logic                        status_nxt;
  logic [plt_pkg::RDV_W-1:0]   rdv_nxt;
  logic [plt_pkg::FND_W-1:0]   fnd_nxt;
  logic [plt_pkg::POS_W:0]     pos_x;
  logic [plt_pkg::POS_W:0]     count_x;
  logic                        shift_up;
  logic                        shift_down;

  plt_pkg::plt_ctl_t           ctl;
  logic [plt_pkg::ENTRY_W-1:0] entries [plt_pkg::CAPACITY];
  logic [plt_pkg::ENTRY_W-1:0] taps    [plt_pkg::CAPACITY];
  logic [plt_pkg::CAPACITY-1:0] hits;
  logic [plt_pkg::ENTRY_W-1:0] tap_or;
  logic [plt_pkg::FND_W-1:0]   found_pos;

  // Handshake.
  assign in_tready = (state_r == plt_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign do_exec   = (state_r == plt_pkg::ST_EXEC) && out_free;

  // Capture the accepted item.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= in_tuser;
      pos_r  <= in_tdata[plt_pkg::POS_W-1:0];
      elem_r <= in_tdata[plt_pkg::POS_W +: plt_pkg::ENTRY_W];
    end
  end

  // Position checks against the current list length.
  assign pos_x   = {1'b0, pos_r};
  assign count_x = (plt_pkg::POS_W + 1)'(count_r);
  assign ins_ok  = (pos_r != '0) && (pos_x <= count_x + 1'b1)
                   && (count_x < (plt_pkg::POS_W + 1)'(plt_pkg::CAPACITY));
  assign rd_ok   = (pos_r != '0) && (pos_x <= count_x);

  // Command decode: result fields and new length.
  always_comb begin
    status_nxt = 1'b0;
    rdv_nxt    = '0;
    fnd_nxt    = '0;
    count_nxt  = count_r;
    shift_up   = 1'b0;
    shift_down = 1'b0;
    case (plt_pkg::cmd_t'(cmd_r))
      plt_pkg::CMD_INSERT: begin
        if (ins_ok) begin
          shift_up  = do_exec;
          count_nxt = count_r + 1'b1;
        end else begin
          status_nxt = 1'b1;
        end
      end
      plt_pkg::CMD_GET: begin
        if (rd_ok) begin
          rdv_nxt = plt_pkg::RDV_W'(tap_or);
        end else begin
          status_nxt = 1'b1;
        end
      end
      plt_pkg::CMD_DELETE: begin
        if (rd_ok) begin
          rdv_nxt    = plt_pkg::RDV_W'(tap_or);
          shift_down = do_exec;
          count_nxt  = count_r - 1'b1;
        end else begin
          status_nxt = 1'b1;
        end
      end
      plt_pkg::CMD_LOCATE: begin
        fnd_nxt = found_pos;
      end
      plt_pkg::CMD_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        status_nxt = 1'b1;
      end
    endcase
  end

  // Broadcast control to the chain.
  assign ctl = {shift_up, shift_down, plt_pkg::IDX_W'(pos_r - 1'b1), elem_r, count_r};

  // Chain of storage cells.
  for (genvar i = 0; i < plt_pkg::CAPACITY; i++) begin : g_cell
    logic [plt_pkg::ENTRY_W-1:0] left_v;
    logic [plt_pkg::ENTRY_W-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = elem_r;
    end else begin : g_mid_l
      assign left_v = entries[i-1];
    end
    if (i == plt_pkg::CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = entries[i+1];
    end

    plt_cell u_cell (
      .clk       (clk),
      .idx       (plt_pkg::IDX_W'(i)),
      .ctl       (ctl),
      .left_val  (left_v),
      .right_val (right_v),
      .entry     (entries[i]),
      .hit       (hits[i]),
      .tap       (taps[i])
    );
  end

  // Selected entry: only the cell at the slot drives a nonzero tap.
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < plt_pkg::CAPACITY; i++) begin
      tap_or = tap_or | taps[i];
    end
  end

  plt_find u_find (
    .hits     (hits),
    .position (found_pos)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      plt_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = plt_pkg::ST_EXEC;
        end
      end
      plt_pkg::ST_EXEC: begin
        if (out_free) begin
          state_nxt = plt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = plt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plt_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_exec) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (do_exec) begin
      status_r <= status_nxt;
      rdv_r    <= rdv_nxt;
      fnd_r    <= fnd_nxt;
      len_r    <= plt_pkg::LEN_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {2'b00, len_r, fnd_r, rdv_r};

  // The list never grows past its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= plt_pkg::CNT_W'(plt_pkg::CAPACITY))
    else $error("list length exceeds capacity");

  // An accepted item enters the execute state in the following cycle.
  a_acc_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == plt_pkg::ST_EXEC))
    else $error("accepted item did not enter execute");

  // A fresh result reports the list length the list now holds.
  a_len_match: assert property (@(posedge clk) disable iff (!rst_n)
    $past(do_exec) |-> (len_r == plt_pkg::LEN_W'(count_r)))
    else $error("result length disagrees with list length");

  // A result is only loaded from an execute cycle.
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == plt_pkg::ST_EXEC))
    else $error("result appeared without an execute cycle");

endmodule

`default_nettype wire

@@ rtl/plt_cell.sv @@
// ---------------------------------------------------------------------------
// plt_cell
// One storage cell of the list chain. It holds a single entry, takes its
// neighbor's entry on a shift, loads the new element at the insert slot and
// reports a locate match, and its entry when its position is selected.
// ---------------------------------------------------------------------------
`default_nettype none

module plt_cell (
  input  wire logic                        clk,
  input  wire logic [plt_pkg::IDX_W-1:0]   idx,
  input  wire plt_pkg::plt_ctl_t           ctl,
  input  wire logic [plt_pkg::ENTRY_W-1:0] left_val,
  input  wire logic [plt_pkg::ENTRY_W-1:0] right_val,
  output logic      [plt_pkg::ENTRY_W-1:0] entry,
  output logic                             hit,
  output logic      [plt_pkg::ENTRY_W-1:0] tap
);

  logic [plt_pkg::ENTRY_W-1:0] entry_r;
  logic [plt_pkg::ENTRY_W-1:0] entry_nxt;
  logic                        at_slot;
  logic                        above_slot;
  logic                        in_list;

  // Position of this cell relative to the command's slot and list length.
  assign at_slot    = (idx == ctl.slot);
  assign above_slot = (idx > ctl.slot);
  assign in_list    = ({1'b0, idx} < ctl.count);

  // Next entry: shift up above the slot, load at the slot, shift down from it.
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.shift_up) begin
      if (above_slot) begin
        entry_nxt = left_val;
      end else if (at_slot) begin
        entry_nxt = ctl.elem;
      end
    end else if (ctl.shift_down) begin
      if (above_slot || at_slot) begin
        entry_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // Local results for the read mux and the first-match search.
  assign entry = entry_r;
  assign hit   = in_list && (entry_r == ctl.elem);
  assign tap   = at_slot ? entry_r : '0;

endmodule

`default_nettype wire

@@ rtl/plt_find.sv @@
// ---------------------------------------------------------------------------
// plt_find
// First-match search over the chain. Turns the per-cell match flags into the
// one-based position of the lowest matching cell, or zero when none match.
// ---------------------------------------------------------------------------
`default_nettype none

module plt_find (
  input  wire logic [plt_pkg::CAPACITY-1:0] hits,
  output logic      [plt_pkg::FND_W-1:0]    position
);

  // Scan from the top so the lowest matching cell wins.
  always_comb begin
    position = '0;
    for (int i = plt_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (hits[i]) begin
        position = plt_pkg::FND_W'(i + 1);
      end
    end
  end

endmodule

`default_nettype wire
